// ----- rtl/lckbl_pkg.sv -----
`default_nettype none
package lckbl_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VOLT_DIV,
    ST_GAIN_DIV,
    ST_STEP_MUL,
    ST_ERR_MUL,
    ST_Q_MUL,
    ST_FORCE_MUL,
    ST_FORCE_DIV,
    ST_IDX_DIV,
    ST_CURVE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    CFG_FULL_SCALE  = 3'd0,
    CFG_ZERO        = 3'd1,
    CFG_MAX_FORCE   = 3'd2,
    CFG_MEAS_NOISE  = 3'd3,
    CFG_PROC_NOISE  = 3'd4,
    CFG_CALIBRATING = 3'd5
  } cfg_idx_e;

  localparam int unsigned DIV_W = 48;

  // Control for the shared divider: start pulse and the operands.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/lckbl_if.sv -----
`default_nettype none
interface lckbl_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface lckbl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  brake_level;
  logic [15:0] force_value;
  logic [15:0] filtered_volts;
  logic [15:0] lowest_seen;
  logic [15:0] highest_seen;
  modport source (output valid, output brake_level, output force_value,
                  output filtered_volts, output lowest_seen, output highest_seen,
                  input ready);
  modport sink (input valid, input brake_level, input force_value,
                input filtered_volts, input lowest_seen, input highest_seen,
                output ready);
endinterface

interface lckbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lckbl_div.sv -----
`default_nettype none
module lckbl_div
  import lckbl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DIV_W:0]   trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DIV_W]) begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// ----- rtl/lckbl_curve.sv -----
`default_nettype none
module lckbl_curve #(
  parameter int unsigned IDX_BITS = 10
) (
  input  wire logic              clk_i,
  input  wire logic [IDX_BITS:0] idx_i,
  output logic [7:0]             level_o
);

  localparam int unsigned SIZE = (1 << IDX_BITS) + 1;
  localparam real         STEP = 1.0 / real'(1 << IDX_BITS);

  // Table built at elaboration: floor(255 * (i / 2^IDX_BITS)^0.7).
  function automatic logic [7:0] curve_val(input int unsigned i);
    real x, y;
    int unsigned lvl;
    x = real'(i) * STEP;
    if (i == 0) return 8'd0;
    y = 255.0 * $exp(0.7 * $ln(x));
    lvl = int'($floor(y + 1.0e-9));
    if (lvl > 255) lvl = 255;
    return 8'(lvl);
  endfunction

  logic [7:0] rom [SIZE];

  for (genvar g = 0; g < SIZE; g++) begin : g_rom
    assign rom[g] = curve_val(g);
  end

  always_ff @(posedge clk_i) begin
    level_o <= rom[idx_i];
  end

endmodule
`default_nettype wire

// ----- rtl/load_cell_kalman_brake_level.sv -----
// Channel | Dir | Payload
// in_if   | in  | adc_sample
// out_if  | out | brake_level, force_value, filtered_volts, lowest_seen, highest_seen
// cfg_if  | in  | index, data
//
// After a sample is accepted the block folds it to volts, divides for the gain,
// runs the filter and force steps, divides for the curve index and looks up the
// level. The two 48-bit divisions (gain and curve index) run on the shared
// restoring divider.
// Reset clears the filter state and loads the register defaults.
// The result waits in an output register until it is transferred, so the next
// sample can be taken meanwhile; only a second finished result stalls the block.
`default_nettype none
module load_cell_kalman_brake_level
  import lckbl_pkg::*;
#(
  parameter int unsigned ADC_BITS         = 12,
  parameter int unsigned CURVE_INDEX_BITS = 10
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lckbl_in_if.sink    in_if,
  lckbl_out_if.source out_if,
  lckbl_cfg_if.sink   cfg_if
);

  localparam logic [DIV_W-1:0] ADC_MAX = DIV_W'((1 << ADC_BITS) - 1);
  localparam logic [11:0]      ADC_MASK = 12'(ADC_MAX);
  // The force span divides by 33792 = 2^10 * 33: a shift, then a reciprocal
  // multiplication by ceil(2^31 / 33), exact for every product that can occur.
  localparam int unsigned      SPAN_SHIFT = 10;
  localparam logic [31:0]      FORCE_RECIP = 32'd65075263;
  localparam int unsigned      FORCE_RECIP_SHIFT = 31;

  state_e state_q, state_d;

  logic [15:0] fs_q, zero_q, maxf_q, rn_q, qn_q;
  logic        cal_q;
  logic [15:0] est_q, est_d, err_q, err_d, low_q, low_d, high_q, high_d;
  logic        first_q, first_d;

  // Shared working registers: a multiplier result and the operands in use.
  logic [DIV_W-1:0] acc_q, acc_d;
  logic [16:0]      gain_q, gain_d;
  logic [15:0]      v_q, v_d, step_q, step_d, force_q, force_d;
  logic [CURVE_INDEX_BITS:0] idx_q, idx_d;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [63:0]      span_quo;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       level;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic [16:0]      diff;

  // Output register holding a finished result until it is transferred.
  logic [7:0]  res_level_q, res_level_d;
  logic [15:0] res_force_q, res_force_d, res_volts_q, res_volts_d;
  logic [15:0] res_low_q, res_low_d, res_high_q, res_high_d;

  assign mul_p = mul_a * mul_b;

  lckbl_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  lckbl_curve #(.IDX_BITS(CURVE_INDEX_BITS)) u_curve (
    .clk_i, .idx_i(idx_q), .level_o(level)
  );

  assign in_if.ready  = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  always_comb begin
    state_d = state_q;
    est_d = est_q; err_d = err_q; low_d = low_q; high_d = high_q;
    first_d = first_q; acc_d = acc_q; gain_d = gain_q; v_d = v_q;
    step_d = step_q; force_d = force_q; idx_d = idx_q;
    out_valid_d = out_valid_q;
    res_level_d = res_level_q; res_force_d = res_force_q; res_volts_d = res_volts_q;
    res_low_d = res_low_q; res_high_d = res_high_q;
    mul_a = '0; mul_b = '0;
    dreq = '0;
    diff = '0;
    span_quo = '0;
    if (out_if.valid && out_if.ready) out_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          mul_a = 32'(in_if.adc_sample & ADC_MASK);
          mul_b = 32'(fs_q);
          acc_d = DIV_W'(mul_p) + (ADC_MAX >> 1);
          v_d   = '0;
          if (first_q) begin
            err_d   = rn_q;
            first_d = 1'b0;
          end
          state_d = ST_VOLT_DIV;
        end
      end
      ST_VOLT_DIV: begin
        // Division by 2^ADC_BITS - 1 by folding: the high part joins the
        // quotient and is added back into the low part until it vanishes.
        if (acc_q > ADC_MAX) begin
          v_d   = v_q + 16'(acc_q >> ADC_BITS);
          acc_d = (acc_q >> ADC_BITS) + (acc_q & ADC_MAX);
        end else begin
          if (acc_q == ADC_MAX) v_d = v_q + 16'd1;
          dreq.start    = 1'b1;
          dreq.dividend = DIV_W'({err_q, 16'h0});
          dreq.divisor  = DIV_W'(err_q) + DIV_W'(rn_q);
          state_d = ST_GAIN_DIV;
        end
      end
      ST_GAIN_DIV: begin
        if (drsp.done) begin
          // A zero divisor only arises when both error and noise are zero.
          gain_d = (err_q == 16'd0 && rn_q == 16'd0) ? 17'd0 : drsp.quotient[16:0];
          state_d = ST_STEP_MUL;
        end
      end
      ST_STEP_MUL: begin
        diff  = (v_q >= est_q) ? 17'(v_q - est_q) : 17'(est_q - v_q);
        mul_a = 32'(gain_q); mul_b = 32'(diff);
        step_d = 16'((mul_p + 64'h8000) >> 16);
        est_d  = (v_q >= est_q) ? est_q + step_d : est_q - step_d;
        state_d = ST_ERR_MUL;
      end
      ST_ERR_MUL: begin
        mul_a = 32'(17'h10000 - gain_q); mul_b = 32'(err_q);
        acc_d = DIV_W'((mul_p + 64'h8000) >> 16);
        state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        mul_a = 32'(step_q); mul_b = 32'(qn_q);
        acc_d = acc_q + DIV_W'((mul_p + 64'h80000) >> 20);
        err_d = (acc_d > DIV_W'(16'hFFFF)) ? 16'hFFFF : acc_d[15:0];
        if (cal_q) begin
          if (est_q < low_q)  low_d  = est_q;
          if (est_q > high_q) high_d = est_q;
        end
        state_d = ST_FORCE_MUL;
      end
      ST_FORCE_MUL: begin
        mul_a = 32'(est_q - zero_q); mul_b = 32'(maxf_q) * 32'd5;
        acc_d = DIV_W'(mul_p);
        state_d = ST_FORCE_DIV;
        if (est_q <= zero_q) begin
          force_d = '0;
          state_d = ST_IDX_DIV;
          dreq.start = 1'b1;
          dreq.dividend = '0;
          dreq.divisor = DIV_W'(maxf_q);
        end
      end
      ST_FORCE_DIV: begin
        mul_a = 32'(acc_q >> SPAN_SHIFT); mul_b = FORCE_RECIP;
        span_quo = mul_p >> FORCE_RECIP_SHIFT;
        force_d = (span_quo > 64'(maxf_q)) ? maxf_q : span_quo[15:0];
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(force_d) << CURVE_INDEX_BITS;
        dreq.divisor  = DIV_W'(maxf_q);
        state_d = ST_IDX_DIV;
      end
      ST_IDX_DIV: begin
        if (drsp.done) begin
          if (maxf_q == 16'd0) idx_d = '0;
          else if (drsp.quotient > DIV_W'(1 << CURVE_INDEX_BITS))
            idx_d = (CURVE_INDEX_BITS+1)'(1 << CURVE_INDEX_BITS);
          else idx_d = drsp.quotient[CURVE_INDEX_BITS:0];
          state_d = ST_CURVE;
        end
      end
      ST_CURVE: state_d = ST_OUT;
      ST_OUT: begin
        // Wait here while the previous result still occupies the output register.
        if (!out_valid_q || out_if.ready) begin
          res_level_d = (maxf_q == 16'd0) ? 8'd0 : level;
          res_force_d = force_q;
          res_volts_d = est_q;
          res_low_d   = low_q;
          res_high_d  = high_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      fs_q <= 16'd13517; zero_q <= '0; maxf_q <= 16'd25600;
      rn_q <= 16'd256; qn_q <= 16'd655; cal_q <= 1'b0;
      est_q <= '0; err_q <= '0; first_q <= 1'b1;
      low_q <= 16'hFFFF; high_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      est_q <= est_d; err_q <= err_d; first_q <= first_d;
      low_q <= low_d; high_q <= high_d;
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_FULL_SCALE:  fs_q   <= cfg_if.data;
          CFG_ZERO:        zero_q <= cfg_if.data;
          CFG_MAX_FORCE:   maxf_q <= cfg_if.data;
          CFG_MEAS_NOISE:  rn_q   <= cfg_if.data;
          CFG_PROC_NOISE:  qn_q   <= cfg_if.data;
          CFG_CALIBRATING: cal_q  <= cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; gain_q <= gain_d; v_q <= v_d;
    step_q <= step_d; force_q <= force_d; idx_q <= idx_d;
    res_level_q <= res_level_d; res_force_q <= res_force_d; res_volts_q <= res_volts_d;
    res_low_q <= res_low_d; res_high_q <= res_high_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.brake_level    = res_level_q;
  assign out_if.force_value    = res_force_q;
  assign out_if.filtered_volts = res_volts_q;
  assign out_if.lowest_seen    = res_low_q;
  assign out_if.highest_seen   = res_high_q;

endmodule
`default_nettype wire

// ----- rtl/lckbl_checker.sv -----
`default_nettype none
module lckbl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] lowest_seen,
  input wire logic [15:0] highest_seen
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !$rose(out_valid)) else $error("result too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(lowest_seen)
      && $stable(highest_seen)) else $error("result dropped");

endmodule

bind load_cell_kalman_brake_level lckbl_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .lowest_seen(out_if.lowest_seen), .highest_seen(out_if.highest_seen)
);
`default_nettype wire
